/* rtl/cstm_pkg.sv */
// Shared types and constants for the Collatz stopping-time block.
`timescale 1ns / 1ps
`default_nettype none
package cstm_pkg;

   localparam int VALUE_W        = 64;
   localparam int STEPS_W        = 16;
   localparam int STATUS_W       = 2;
   localparam int RSP_FIELDS_W   = STEPS_W + VALUE_W + STATUS_W + 1 + STEPS_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int MEMO_DEPTH_DEF = 1024;
   localparam int TRAJ_DEPTH_DEF = 1024;

   // largest value that may still take 3n+1 without wrapping: (2^64-2)/3
   localparam logic [VALUE_W-1:0] STEP_LIMIT = 64'h5555_5555_5555_5554;
   localparam logic [STEPS_W-1:0] SAT16      = 16'hFFFF;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BUF_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ZERO     = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] next_value;  // value after one map step
      logic               next_in_memo; // next_value below memo depth
      logic               over_limit;  // current value too large to step
      logic               new_peak;    // next_value exceeds running peak
   } step_res_type;

endpackage
`default_nettype wire

/* rtl/cstm_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cstm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/cstm_step.sv */
// Shared Collatz step unit: one map step plus the range and peak compares.
`timescale 1ns / 1ps
`default_nettype none
module cstm_step
   import cstm_pkg::*;
#(
   parameter int MEMO_DEPTH = MEMO_DEPTH_DEF
) (
   input  wire logic [VALUE_W-1:0] value,
   input  wire logic [VALUE_W-1:0] peak,
   output step_res_type            res
);

   logic [VALUE_W-1:0] nxt;

   // odd: 3n+1 as (n<<1)+n+1, even: n>>1
   assign nxt = value[0] ? ({value[VALUE_W-2:0], 1'b0} + value + VALUE_W'(1))
                         : {1'b0, value[VALUE_W-1:1]};

   assign res.next_value   = nxt;
   assign res.next_in_memo = (nxt < VALUE_W'(MEMO_DEPTH));
   assign res.over_limit   = (value > STEP_LIMIT);
   assign res.new_peak     = (nxt > peak);

endmodule
`default_nettype wire

/* rtl/collatz_stopping_time_memo_top.sv */
// Top level: Collatz stopping time with memo table, sequencer and memories.
// Flow: each word is accepted, walked through the shared step unit with each map
//   step stored in the trajectory buffer, written back into the memo from the single
//   trajectory read port when the walk ended at 1 or a memo hit, then loaded as a result.
// Throughput: one word at a time; the next word is taken once the result is loaded.
// Reset: synchronous; afterwards the memo is cleared address by address (entry 1 set
//   to one), with req_tready low during that pass.
`timescale 1ns / 1ps
`default_nettype none
module collatz_stopping_time_memo_top
   import cstm_pkg::*;
#(
   parameter int MEMO_DEPTH = MEMO_DEPTH_DEF,
   parameter int TRAJ_DEPTH = TRAJ_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [VALUE_W-1:0]    req_tdata,  // start_value
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // steps[15:0], highest_value[79:16], status[81:80], new_record[82],
   // best_steps[98:83], zero pad above
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int MA_W  = $clog2(MEMO_DEPTH);
   localparam int TA_W  = $clog2(TRAJ_DEPTH);
   localparam int LEN_W = $clog2(TRAJ_DEPTH + 1);
   localparam int CNT_W = $clog2(TRAJ_DEPTH + 65536) + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_WB,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   n_ff, n_in;
   logic [VALUE_W-1:0]   peak_ff, peak_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 chk_ff, chk_in;
   logic                 sat_ff, sat_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [STEPS_W-1:0]   record_ff, record_in;
   logic [LEN_W-1:0]     wb_idx_ff, wb_idx_in;
   logic                 wb_vld_ff, wb_vld_in;
   logic [CNT_W-1:0]     wb_tv_ff, wb_tv_in;
   logic [MA_W-1:0]      clr_idx_ff, clr_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   step_res_type         step_res;

   logic                 memo_we, memo_re;
   logic [MA_W-1:0]      memo_waddr, memo_raddr;
   logic [STEPS_W-1:0]   memo_wdata, memo_rd;
   logic                 traj_we, traj_re;
   logic [VALUE_W-1:0]   traj_rd;

   logic                 hit;
   logic [CNT_W-1:0]     fin_cnt;
   logic [STEPS_W-1:0]   steps16;
   logic                 wb_in_memo;

   cstm_step #(.MEMO_DEPTH(MEMO_DEPTH)) u_step (
      .value (n_ff),
      .peak  (peak_ff),
      .res   (step_res)
   );

   cstm_ram #(.WIDTH(STEPS_W), .DEPTH(MEMO_DEPTH)) u_memo (
      .clock   (clock),
      .wr_en   (memo_we),
      .wr_addr (memo_waddr),
      .wr_data (memo_wdata),
      .rd_en   (memo_re),
      .rd_addr (memo_raddr),
      .rd_data (memo_rd)
   );

   cstm_ram #(.WIDTH(VALUE_W), .DEPTH(TRAJ_DEPTH)) u_traj (
      .clock   (clock),
      .wr_en   (traj_we),
      .wr_addr (len_ff[TA_W-1:0]),
      .wr_data (n_ff),
      .rd_en   (traj_re),
      .rd_addr (wb_idx_ff[TA_W-1:0]),
      .rd_data (traj_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // memo data is only meaningful the cycle after a step landed below memo depth
   assign hit     = chk_ff && (memo_rd != '0);
   assign fin_cnt = (hit && (memo_rd != SAT16))
                    ? (count_ff + CNT_W'(memo_rd) - CNT_W'(1)) : count_ff;
   assign steps16 = (sat_ff || (count_ff[CNT_W-1:STEPS_W] != '0))
                    ? SAT16 : count_ff[STEPS_W-1:0];
   assign wb_in_memo = (traj_rd < VALUE_W'(MEMO_DEPTH));

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      chk_in       = 1'b0;
      sat_in       = sat_ff;
      status_in    = status_ff;
      record_in    = record_ff;
      wb_idx_in    = wb_idx_ff;
      wb_vld_in    = 1'b0;
      wb_tv_in     = wb_tv_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      memo_we    = 1'b0;
      memo_waddr = '0;
      memo_wdata = '0;
      memo_re    = 1'b0;
      memo_raddr = step_res.next_value[MA_W-1:0];
      traj_we    = 1'b0;
      traj_re    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            memo_we    = 1'b1;
            memo_waddr = clr_idx_ff;
            memo_wdata = (clr_idx_ff == MA_W'(1)) ? STEPS_W'(1) : '0;
            clr_idx_in = clr_idx_ff + MA_W'(1);
            if (clr_idx_ff == MA_W'(MEMO_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               n_in      = req_tdata;
               peak_in   = req_tdata;
               count_in  = '0;
               len_in    = '0;
               sat_in    = 1'b0;
               if (req_tdata == '0) begin
                  status_in = STAT_ZERO;
                  state_in  = S_FINISH;
               end else begin
                  status_in = STAT_OK;
                  state_in  = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (hit || (n_ff == VALUE_W'(1))) begin
               count_in = fin_cnt;
               if (hit && (memo_rd == SAT16)) begin
                  sat_in = 1'b1;
               end
               wb_idx_in = '0;
               wb_tv_in  = fin_cnt + CNT_W'(1);
               if (len_ff == LEN_W'(TRAJ_DEPTH)) begin
                  status_in = STAT_BUF_FULL;
                  state_in  = S_FINISH;
               end else if (len_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_WB;
               end
            end else if (step_res.over_limit) begin
               status_in = STAT_OVERFLOW;
               state_in  = S_FINISH;
            end else if (len_ff == LEN_W'(TRAJ_DEPTH)) begin
               status_in = STAT_BUF_FULL;
               state_in  = S_FINISH;
            end else begin
               traj_we  = 1'b1;
               len_in   = len_ff + LEN_W'(1);
               n_in     = step_res.next_value;
               count_in = count_ff + CNT_W'(1);
               if (step_res.new_peak) begin
                  peak_in = step_res.next_value;
               end
               memo_re = step_res.next_in_memo;
               chk_in  = step_res.next_in_memo;
            end
         end

         S_WB: begin
            // read stage walks the trajectory, write stage fills the memo in the following cycle
            if (wb_idx_ff != len_ff) begin
               traj_re   = 1'b1;
               wb_idx_in = wb_idx_ff + LEN_W'(1);
               wb_vld_in = 1'b1;
            end
            if (wb_vld_ff) begin
               wb_tv_in = wb_tv_ff - CNT_W'(1);
               if (wb_in_memo) begin
                  memo_we    = 1'b1;
                  memo_waddr = traj_rd[MA_W-1:0];
                  memo_wdata = (sat_ff || (wb_tv_ff[CNT_W-1:STEPS_W] != '0))
                               ? SAT16 : wb_tv_ff[STEPS_W-1:0];
               end
            end
            if ((wb_idx_ff == len_ff) && !wb_vld_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (status_ff != STAT_OK) begin
                  rsp_data_in = RSP_DATA_W'({record_ff, 1'b0, status_ff,
                                             {VALUE_W{1'b0}}, {STEPS_W{1'b0}}});
               end else if (steps16 > record_ff) begin
                  record_in   = steps16;
                  rsp_data_in = RSP_DATA_W'({steps16, 1'b1, status_ff, peak_ff, steps16});
               end else begin
                  rsp_data_in = RSP_DATA_W'({record_ff, 1'b0, status_ff, peak_ff, steps16});
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         record_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         wb_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         record_ff    <= record_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         wb_vld_ff    <= wb_vld_in;
      end
      n_ff        <= n_in;
      peak_ff     <= peak_in;
      count_ff    <= count_in;
      len_ff      <= len_in;
      sat_ff      <= sat_in;
      status_ff   <= status_in;
      wb_idx_ff   <= wb_idx_in;
      wb_tv_ff    <= wb_tv_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
